[hw/rtl/bfrc_pkg.sv]
`timescale 1ns / 1ps

package bfrc_pkg;

    localparam int unsigned SeqW     = 16;
    localparam int unsigned HopsW    = 8;
    localparam int unsigned AddrW    = 16;
    localparam int unsigned CountW   = 8;
    localparam int unsigned RandW    = 16;
    localparam int unsigned CfgDataW = 16;
    localparam int unsigned CfgIdxW  = 2;
    // remainder unit retires this many dividend bits per cycle
    localparam int unsigned DivBitsPerStep = 4;
    localparam int unsigned DivSteps       = RandW / DivBitsPerStep;
    localparam int unsigned DivCntW        = $clog2(DivSteps);

    typedef enum logic [1:0] {
        OP_SEND    = 2'd0,
        OP_RECEIVE = 2'd1,
        OP_TICK    = 2'd2,
        OP_CANCEL  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ACT_TRANSMIT   = 2'd0,
        ACT_RETRANSMIT = 2'd1,
        ACT_DELIVER    = 2'd2,
        ACT_DUPLICATE  = 2'd3
    } action_t;

    typedef enum logic [CfgIdxW-1:0] {
        REG_BURST_INTERVAL = 2'd0,
        REG_BURST_LIMIT    = 2'd1,
        REG_OWN_ADDRESS    = 2'd2
    } cfg_index_t;

    localparam logic [CfgDataW-1:0] BurstIntervalReset = 16'd128;
    localparam logic [CountW-1:0]   BurstLimitReset    = 8'd3;
    localparam logic [SeqW-1:0]     SeqWrapLimit       = 16'd255;
    // differences from -5 to -1 count as slightly old packets
    localparam logic [SeqW-1:0]     NearOldLow         = 16'hFFFB;

    typedef struct packed {
        logic load;
        logic div_step;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic has_result;
    } dp_stat_t;

endpackage

[hw/rtl/bfrc_in_if.sv]
`timescale 1ns / 1ps

interface bfrc_in_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       operation;
    logic [bfrc_pkg::SeqW-1:0]        rx_sequence;
    logic [bfrc_pkg::HopsW-1:0]       rx_hops;
    logic [bfrc_pkg::AddrW-1:0]       rx_originator;
    logic [bfrc_pkg::RandW-1:0]       random_value;

    modport source (
        output valid, operation, rx_sequence, rx_hops, rx_originator, random_value,
        input  ready
    );

    modport sink (
        input  valid, operation, rx_sequence, rx_hops, rx_originator, random_value,
        output ready
    );
endinterface

[hw/rtl/bfrc_out_if.sv]
`timescale 1ns / 1ps

interface bfrc_out_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       action;
    logic [bfrc_pkg::SeqW-1:0]        out_sequence;
    logic [bfrc_pkg::HopsW-1:0]       out_hops;
    logic [bfrc_pkg::AddrW-1:0]       out_originator;
    logic [bfrc_pkg::CountW-1:0]      out_burst_count;

    modport source (
        output valid, action, out_sequence, out_hops, out_originator, out_burst_count,
        input  ready
    );

    modport sink (
        input  valid, action, out_sequence, out_hops, out_originator, out_burst_count,
        output ready
    );
endinterface

[hw/rtl/bfrc_ctrl.sv]
`timescale 1ns / 1ps

module bfrc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  bfrc_pkg::dp_stat_t    stat,
    output bfrc_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_COMMIT
    } state_t;

    state_t                          state_reg, state_next;
    logic [bfrc_pkg::DivCntW-1:0]    cnt_reg, cnt_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == bfrc_pkg::DivCntW'(bfrc_pkg::DivSteps - 1))
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                // a result waits here until the output register can take it
                if (!stat.has_result || slot_free)
                begin
                    cmd.commit = 1'b1;
                    if (stat.has_result)
                    begin
                        out_valid_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[hw/rtl/bfrc_datapath.sv]
`timescale 1ns / 1ps

module bfrc_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  bfrc_pkg::ctrl_cmd_t                cmd,
    output bfrc_pkg::dp_stat_t                 stat,
    input  logic                               wr_en,
    input  logic [bfrc_pkg::CfgIdxW-1:0]       wr_index,
    input  logic [bfrc_pkg::CfgDataW-1:0]      wr_data,
    input  logic [1:0]                         operation,
    input  logic [bfrc_pkg::SeqW-1:0]          rx_sequence,
    input  logic [bfrc_pkg::HopsW-1:0]         rx_hops,
    input  logic [bfrc_pkg::AddrW-1:0]         rx_originator,
    input  logic [bfrc_pkg::RandW-1:0]         random_value,
    output logic [1:0]                         action,
    output logic [bfrc_pkg::SeqW-1:0]          out_sequence,
    output logic [bfrc_pkg::HopsW-1:0]         out_hops,
    output logic [bfrc_pkg::AddrW-1:0]         out_originator,
    output logic [bfrc_pkg::CountW-1:0]        out_burst_count
);

    localparam int unsigned HalfW = bfrc_pkg::CfgDataW - 1;

    // configuration
    logic [bfrc_pkg::CfgDataW-1:0]  burst_interval_reg;
    logic [bfrc_pkg::CountW-1:0]    burst_limit_reg;
    logic [bfrc_pkg::AddrW-1:0]     own_address_reg;

    // latched item
    bfrc_pkg::op_t                  op_reg;
    logic [bfrc_pkg::SeqW-1:0]      rx_seq_reg;
    logic [bfrc_pkg::HopsW-1:0]     rx_hops_reg;
    logic [bfrc_pkg::AddrW-1:0]     rx_orig_reg;

    // remainder unit
    logic [bfrc_pkg::RandW-1:0]     dividend_reg;
    logic [bfrc_pkg::RandW-1:0]     rem_reg;
    logic [bfrc_pkg::RandW-1:0]     rem_step;
    logic [HalfW-1:0]               half;

    // connection state
    logic [bfrc_pkg::SeqW-1:0]      last_seq_reg, last_seq_next;
    logic [bfrc_pkg::HopsW-1:0]     stored_hops_reg, stored_hops_next;
    logic [bfrc_pkg::AddrW-1:0]     stored_orig_reg, stored_orig_next;
    logic [bfrc_pkg::CountW-1:0]    burst_cnt_reg, burst_cnt_next;
    logic                           pending_reg, pending_next;
    logic                           armed_reg, armed_next;
    logic [bfrc_pkg::SeqW-1:0]      remaining_reg, remaining_next;

    // result
    logic                           has_result;
    bfrc_pkg::action_t              res_action;
    logic [bfrc_pkg::SeqW-1:0]      res_seq;
    logic [bfrc_pkg::HopsW-1:0]     res_hops;
    logic [bfrc_pkg::AddrW-1:0]     res_orig;
    logic [bfrc_pkg::CountW-1:0]    res_cnt;
    logic [1:0]                     action_reg;
    logic [bfrc_pkg::SeqW-1:0]      out_seq_reg;
    logic [bfrc_pkg::HopsW-1:0]     out_hops_reg;
    logic [bfrc_pkg::AddrW-1:0]     out_orig_reg;
    logic [bfrc_pkg::CountW-1:0]    out_cnt_reg;

    logic [bfrc_pkg::HopsW-1:0]     fwd_hops;
    logic [bfrc_pkg::SeqW-1:0]      seq_diff;
    logic [bfrc_pkg::SeqW-1:0]      seq_inc;
    logic [bfrc_pkg::SeqW-1:0]      delay;
    logic [bfrc_pkg::CountW-1:0]    cnt_inc;

    always_comb
    begin
        if (burst_interval_reg[bfrc_pkg::CfgDataW-1:1] == '0)
        begin
            half = HalfW'(1);
        end
        else
        begin
            half = burst_interval_reg[bfrc_pkg::CfgDataW-1:1];
        end
    end

    // restoring remainder, a few dividend bits per cycle
    always_comb
    begin
        logic [bfrc_pkg::RandW-1:0] r;
        r = rem_reg;
        for (int i = 0; i < int'(bfrc_pkg::DivBitsPerStep); i++)
        begin
            r = {r[bfrc_pkg::RandW-2:0], dividend_reg[bfrc_pkg::RandW-1-i]};
            if (r >= {1'b0, half})
            begin
                r = r - {1'b0, half};
            end
        end
        rem_step = r;
    end

    assign delay    = {1'b0, half} + rem_reg;
    assign fwd_hops = (rx_hops_reg == '1) ? rx_hops_reg : rx_hops_reg + 1'b1;
    assign seq_diff = rx_seq_reg - last_seq_reg;
    assign seq_inc  = last_seq_reg + 1'b1;
    assign cnt_inc  = (burst_cnt_reg == '1) ? burst_cnt_reg : burst_cnt_reg + 1'b1;

    always_comb
    begin
        last_seq_next    = last_seq_reg;
        stored_hops_next = stored_hops_reg;
        stored_orig_next = stored_orig_reg;
        burst_cnt_next   = burst_cnt_reg;
        pending_next     = pending_reg;
        armed_next       = armed_reg;
        remaining_next   = remaining_reg;
        has_result       = 1'b0;
        res_action       = bfrc_pkg::ACT_TRANSMIT;
        res_seq          = rx_seq_reg;
        res_hops         = fwd_hops;
        res_orig         = rx_orig_reg;
        res_cnt          = burst_cnt_reg;
        case (op_reg)
            bfrc_pkg::OP_SEND:
            begin
                last_seq_next    = (seq_inc > bfrc_pkg::SeqWrapLimit) ?
                                   bfrc_pkg::SeqW'(1) : seq_inc;
                stored_hops_next = '0;
                stored_orig_next = own_address_reg;
                burst_cnt_next   = bfrc_pkg::CountW'(1);
                pending_next     = 1'b1;
                armed_next       = 1'b1;
                remaining_next   = delay;
                has_result       = 1'b1;
                res_action       = bfrc_pkg::ACT_TRANSMIT;
                res_seq          = last_seq_next;
                res_hops         = '0;
                res_orig         = own_address_reg;
                res_cnt          = bfrc_pkg::CountW'(1);
            end
            bfrc_pkg::OP_RECEIVE:
            begin
                if (seq_diff == '0)
                begin
                    has_result = 1'b1;
                    res_action = bfrc_pkg::ACT_DUPLICATE;
                end
                else if (seq_diff < bfrc_pkg::NearOldLow)
                begin
                    last_seq_next    = rx_seq_reg;
                    stored_hops_next = fwd_hops;
                    stored_orig_next = rx_orig_reg;
                    burst_cnt_next   = bfrc_pkg::CountW'(1);
                    pending_next     = 1'b1;
                    if (burst_limit_reg > bfrc_pkg::CountW'(1))
                    begin
                        armed_next     = 1'b1;
                        remaining_next = delay;
                    end
                    else
                    begin
                        armed_next     = 1'b0;
                        remaining_next = '0;
                    end
                    has_result = 1'b1;
                    res_action = bfrc_pkg::ACT_DELIVER;
                    res_cnt    = bfrc_pkg::CountW'(1);
                end
            end
            bfrc_pkg::OP_TICK:
            begin
                if (armed_reg)
                begin
                    if (remaining_reg > bfrc_pkg::SeqW'(1))
                    begin
                        remaining_next = remaining_reg - 1'b1;
                    end
                    else
                    begin
                        remaining_next = '0;
                        armed_next     = 1'b0;
                        if (pending_reg)
                        begin
                            burst_cnt_next = cnt_inc;
                            if (cnt_inc < burst_limit_reg)
                            begin
                                armed_next     = 1'b1;
                                remaining_next = delay;
                            end
                            has_result = 1'b1;
                            res_action = bfrc_pkg::ACT_RETRANSMIT;
                            res_seq    = last_seq_reg;
                            res_hops   = stored_hops_reg;
                            res_orig   = stored_orig_reg;
                            res_cnt    = cnt_inc;
                        end
                    end
                end
            end
            bfrc_pkg::OP_CANCEL:
            begin
                armed_next     = 1'b0;
                remaining_next = '0;
                pending_next   = 1'b0;
            end
            default:
            begin
                has_result = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_interval_reg <= bfrc_pkg::BurstIntervalReset;
            burst_limit_reg    <= bfrc_pkg::BurstLimitReset;
            own_address_reg    <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                bfrc_pkg::REG_BURST_INTERVAL: burst_interval_reg <= wr_data;
                bfrc_pkg::REG_BURST_LIMIT:    burst_limit_reg    <= wr_data[bfrc_pkg::CountW-1:0];
                bfrc_pkg::REG_OWN_ADDRESS:    own_address_reg    <= wr_data;
                default:                      own_address_reg    <= own_address_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_seq_reg    <= '0;
            stored_hops_reg <= '0;
            stored_orig_reg <= '0;
            burst_cnt_reg   <= '0;
            pending_reg     <= 1'b0;
            armed_reg       <= 1'b0;
            remaining_reg   <= '0;
        end
        else if (cmd.commit)
        begin
            last_seq_reg    <= last_seq_next;
            stored_hops_reg <= stored_hops_next;
            stored_orig_reg <= stored_orig_next;
            burst_cnt_reg   <= burst_cnt_next;
            pending_reg     <= pending_next;
            armed_reg       <= armed_next;
            remaining_reg   <= remaining_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= bfrc_pkg::op_t'(operation);
            rx_seq_reg   <= rx_sequence;
            rx_hops_reg  <= rx_hops;
            rx_orig_reg  <= rx_originator;
            dividend_reg <= random_value;
            rem_reg      <= '0;
        end
        else if (cmd.div_step)
        begin
            dividend_reg <= dividend_reg << bfrc_pkg::DivBitsPerStep;
            rem_reg      <= rem_step;
        end
        if (cmd.commit && has_result)
        begin
            action_reg   <= res_action;
            out_seq_reg  <= res_seq;
            out_hops_reg <= res_hops;
            out_orig_reg <= res_orig;
            out_cnt_reg  <= res_cnt;
        end
    end

    assign stat.has_result = has_result;
    assign action          = action_reg;
    assign out_sequence    = out_seq_reg;
    assign out_hops        = out_hops_reg;
    assign out_originator  = out_orig_reg;
    assign out_burst_count = out_cnt_reg;

endmodule

[hw/rtl/burst_flood_retransmit_control_core.sv]
`timescale 1ns / 1ps

// channel    direction   carries
// events     in          operation, rx_sequence, rx_hops, rx_originator, random_value
// results    out         action, out_sequence, out_hops, out_originator, out_burst_count
// wr_*       in          register writes, no read-back
//
// one item at a time, in order: accept, remainder steps, update
// the remainder unit retires 4 bits of random_value per cycle
// a result waits in the output register; the next item is taken meanwhile,
// but its update, if it has a result, waits until that register is free
// reset is asynchronous; no clearing pass after reset

module burst_flood_retransmit_control_core (
    input  logic                               clk,
    input  logic                               rst_n,
    bfrc_in_if.sink                            events,
    bfrc_out_if.source                         results,
    input  logic                               wr_en,
    input  logic [bfrc_pkg::CfgIdxW-1:0]       wr_index,
    input  logic [bfrc_pkg::CfgDataW-1:0]      wr_data
);

    bfrc_pkg::ctrl_cmd_t cmd;
    bfrc_pkg::dp_stat_t  stat;

    bfrc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (events.valid),
        .in_ready  (events.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bfrc_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .wr_en           (wr_en),
        .wr_index        (wr_index),
        .wr_data         (wr_data),
        .operation       (events.operation),
        .rx_sequence     (events.rx_sequence),
        .rx_hops         (events.rx_hops),
        .rx_originator   (events.rx_originator),
        .random_value    (events.random_value),
        .action          (results.action),
        .out_sequence    (results.out_sequence),
        .out_hops        (results.out_hops),
        .out_originator  (results.out_originator),
        .out_burst_count (results.out_burst_count)
    );

`ifndef SYNTHESIS
    // only one item in flight
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (events.valid && events.ready) |=> !events.ready)
        else $error("item accepted while another is in work");

    // a new result comes only from an update cycle, never from the idle state
    a_result_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(results.valid) |-> !$past(events.ready))
        else $error("result appeared without an update cycle");

    // an accepted item cannot produce a result in the very next cycle
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (events.valid && events.ready) |=> !$rose(results.valid))
        else $error("result appeared before the remainder unit finished");
`endif

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int CycleLimit = 200000;
    localparam int HoldCycles = 300;
    localparam int IdleWait   = 20;
    localparam int DrainLimit = 5000;
    localparam int Phases     = 8;
    localparam int PhaseItems = 60;

    typedef struct packed {
        bfrc_pkg::op_t                    op;
        logic [bfrc_pkg::SeqW-1:0]        seq;
        logic [bfrc_pkg::HopsW-1:0]       hops;
        logic [bfrc_pkg::AddrW-1:0]       orig;
        logic [bfrc_pkg::RandW-1:0]       rnd;
    } event_t;

    typedef struct packed {
        bfrc_pkg::action_t                act;
        logic [bfrc_pkg::SeqW-1:0]        seq;
        logic [bfrc_pkg::HopsW-1:0]       hops;
        logic [bfrc_pkg::AddrW-1:0]       orig;
        logic [bfrc_pkg::CountW-1:0]      count;
    } result_t;

    typedef struct {
        bit                               is_reg;
        bfrc_pkg::cfg_index_t             idx;
        logic [bfrc_pkg::CfgDataW-1:0]    data;
        event_t                           ev;
        bit                               typed;
        bit                               has_exp;
        result_t                          exp;
    } stim_row_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             wr_en = 1'b0;
    logic [bfrc_pkg::CfgIdxW-1:0]     wr_index = '0;
    logic [bfrc_pkg::CfgDataW-1:0]    wr_data = '0;

    bfrc_in_if  ev_if ();
    bfrc_out_if res_if ();

    burst_flood_retransmit_control_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .events   (ev_if),
        .results  (res_if),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow of the connection state and registers
    logic [bfrc_pkg::SeqW-1:0]     cur_seq;
    logic [bfrc_pkg::HopsW-1:0]    held_hops;
    logic [bfrc_pkg::AddrW-1:0]    held_orig;
    logic [bfrc_pkg::CountW-1:0]   tx_count;
    bit                            held_valid;
    bit                            timer_on;
    logic [15:0]                   timer_left;
    logic [15:0]                   interval_reg;
    logic [bfrc_pkg::CountW-1:0]   limit_reg;
    logic [bfrc_pkg::AddrW-1:0]    addr_reg;

    result_t             flood_results[$];
    stim_row_t           stim_table[$];
    int                  error_count = 0;
    int                  cycle_count = 0;
    bit                  hold_request = 1'b0;
    bit                  no_idle = 1'b0;
    bit                  pressing = 1'b0;

    task automatic flag_error(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        error_count++;
    endtask

    function automatic logic [15:0] retx_delay(input logic [bfrc_pkg::RandW-1:0] rnd);
        int unsigned half;
        half = interval_reg >> 1;
        if (half == 0)
            half = 1;
        return 16'(half + rnd % half);
    endfunction

    function automatic bit flood_step(input event_t ev, output result_t res);
        logic [bfrc_pkg::HopsW-1:0] fwd;
        logic [bfrc_pkg::SeqW-1:0]  diff;
        res = '0;
        case (ev.op)
            bfrc_pkg::OP_SEND:
            begin
                cur_seq = cur_seq + 1'b1;
                if (cur_seq > bfrc_pkg::SeqWrapLimit)
                    cur_seq = 16'd1;
                held_hops = '0;
                held_orig = addr_reg;
                tx_count = 8'd1;
                held_valid = 1'b1;
                timer_left = retx_delay(ev.rnd);
                timer_on = 1'b1;
                res = '{bfrc_pkg::ACT_TRANSMIT, cur_seq, 8'd0, held_orig, 8'd1};
                return 1'b1;
            end
            bfrc_pkg::OP_RECEIVE:
            begin
                fwd = (ev.hops == {bfrc_pkg::HopsW{1'b1}}) ? ev.hops : ev.hops + 1'b1;
                diff = ev.seq - cur_seq;
                if (diff == '0)
                begin
                    res = '{bfrc_pkg::ACT_DUPLICATE, ev.seq, fwd, ev.orig, tx_count};
                    return 1'b1;
                end
                // slightly old packets fall through silently
                if (diff[bfrc_pkg::SeqW-1] && diff >= bfrc_pkg::NearOldLow)
                    return 1'b0;
                cur_seq = ev.seq;
                held_hops = fwd;
                held_orig = ev.orig;
                tx_count = 8'd1;
                held_valid = 1'b1;
                if (limit_reg > 1)
                begin
                    timer_left = retx_delay(ev.rnd);
                    timer_on = 1'b1;
                end
                else
                begin
                    timer_left = '0;
                    timer_on = 1'b0;
                end
                res = '{bfrc_pkg::ACT_DELIVER, ev.seq, fwd, ev.orig, 8'd1};
                return 1'b1;
            end
            bfrc_pkg::OP_TICK:
            begin
                if (!timer_on)
                    return 1'b0;
                if (timer_left > 1)
                begin
                    timer_left = timer_left - 1'b1;
                    return 1'b0;
                end
                timer_left = '0;
                timer_on = 1'b0;
                if (!held_valid)
                    return 1'b0;
                if (tx_count != {bfrc_pkg::CountW{1'b1}})
                    tx_count = tx_count + 1'b1;
                if (tx_count < limit_reg)
                begin
                    timer_left = retx_delay(ev.rnd);
                    timer_on = 1'b1;
                end
                res = '{bfrc_pkg::ACT_RETRANSMIT, cur_seq, held_hops, held_orig, tx_count};
                return 1'b1;
            end
            default:
            begin
                timer_on = 1'b0;
                timer_left = '0;
                held_valid = 1'b0;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic int pick_gap();
        if (no_idle || pressing)
            return 0;
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(1, 19);
        return 0;
    endfunction

    // mostly sequences close to the current one so that duplicates and old packets occur
    function automatic event_t pick_event(input bit send_only);
        event_t ev;
        int     k;
        k = $urandom_range(0, 99);
        if (send_only || k < 14)
            ev.op = bfrc_pkg::OP_SEND;
        else if (k < 50)
            ev.op = bfrc_pkg::OP_RECEIVE;
        else if (k < 95)
            ev.op = bfrc_pkg::OP_TICK;
        else
            ev.op = bfrc_pkg::OP_CANCEL;
        k = $urandom_range(0, 9);
        if (k < 4)
            ev.seq = cur_seq + 16'($urandom_range(1, 4));
        else if (k < 6)
            ev.seq = cur_seq;
        else if (k < 8)
            ev.seq = cur_seq - 16'($urandom_range(1, 6));
        else
            ev.seq = 16'($urandom_range(0, 65535));
        ev.hops = ($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom_range(0, 255));
        ev.orig = 16'($urandom_range(0, 65535));
        ev.rnd = 16'($urandom_range(0, 65535));
        return ev;
    endfunction

    task automatic issue_event(input event_t ev, input int gap, input bit typed,
                               input bit has_exp, input result_t exp);
        result_t predicted;
        bit      has;
        if (gap > 0)
        begin
            @(negedge clk);
            ev_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        ev_if.valid <= 1'b1;
        ev_if.operation <= ev.op;
        ev_if.rx_sequence <= ev.seq;
        ev_if.rx_hops <= ev.hops;
        ev_if.rx_originator <= ev.orig;
        ev_if.random_value <= ev.rnd;
        do
            @(posedge clk);
        while (!(ev_if.valid === 1'b1 && ev_if.ready === 1'b1));
        has = flood_step(ev, predicted);
        if (typed)
        begin
            has = has_exp;
            predicted = exp;
        end
        if (has)
            flood_results.push_back(predicted);
    endtask

    task automatic write_reg(input bfrc_pkg::cfg_index_t idx,
                             input logic [bfrc_pkg::CfgDataW-1:0] data);
        @(negedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= data;
        @(negedge clk);
        wr_en <= 1'b0;
        case (idx)
            bfrc_pkg::REG_BURST_INTERVAL: interval_reg = data;
            bfrc_pkg::REG_BURST_LIMIT:    limit_reg = data[bfrc_pkg::CountW-1:0];
            bfrc_pkg::REG_OWN_ADDRESS:    addr_reg = data;
            default:                      ;
        endcase
    endtask

    task automatic wait_idle();
        @(negedge clk);
        ev_if.valid <= 1'b0;
        while (flood_results.size() != 0)
            @(posedge clk);
        repeat (IdleWait) @(posedge clk);
    endtask

    task automatic add_reg(input bfrc_pkg::cfg_index_t idx,
                           input logic [bfrc_pkg::CfgDataW-1:0] data);
        stim_row_t row;
        row.is_reg = 1'b1;
        row.idx = idx;
        row.data = data;
        row.typed = 1'b0;
        row.has_exp = 1'b0;
        stim_table.push_back(row);
    endtask

    task automatic add_event(input bfrc_pkg::op_t op, input logic [15:0] seq,
                             input logic [7:0] hops,
                             input logic [15:0] orig, input logic [15:0] rnd,
                             input bit typed, input bit has_exp, input bfrc_pkg::action_t act,
                             input logic [15:0] eseq, input logic [7:0] ehops,
                             input logic [15:0] eorig, input logic [7:0] ecnt);
        stim_row_t row;
        row.is_reg = 1'b0;
        row.data = '0;
        row.ev = '{op, seq, hops, orig, rnd};
        row.typed = typed;
        row.has_exp = has_exp;
        row.exp = '{act, eseq, ehops, eorig, ecnt};
        stim_table.push_back(row);
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CycleLimit)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1)
        begin
            got = '{bfrc_pkg::action_t'(res_if.action), res_if.out_sequence, res_if.out_hops,
                    res_if.out_originator, res_if.out_burst_count};
            if (flood_results.size() == 0)
                flag_error($sformatf("unexpected result action %0d seq %h",
                                     got.act, got.seq));
            else
            begin
                want = flood_results.pop_front();
                if (got.act !== want.act)
                    flag_error($sformatf("action got %0d want %0d", got.act, want.act));
                if (got.seq !== want.seq)
                    flag_error($sformatf("sequence got %h want %h", got.seq, want.seq));
                if (got.hops !== want.hops)
                    flag_error($sformatf("hops got %h want %h", got.hops, want.hops));
                if (got.orig !== want.orig)
                    flag_error($sformatf("originator got %h want %h", got.orig, want.orig));
                if (got.count !== want.count)
                    flag_error($sformatf("burst count got %0d want %0d",
                                         got.count, want.count));
            end
        end
    end

    // result side: random stalls, free runs, and one long hold-off on request
    initial
    begin
        int run;
        res_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                res_if.ready <= 1'b0;
                repeat (HoldCycles - 1) @(negedge clk);
                hold_request = 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 3) == 0)
            begin
                res_if.ready <= 1'b0;
                run = $urandom_range(1, 19);
                repeat (run - 1) @(negedge clk);
            end
            else
            begin
                res_if.ready <= 1'b1;
                run = $urandom_range(1, 40);
                repeat (run - 1) @(negedge clk);
            end
        end
    end

    initial
    begin
        event_t      ev;
        result_t     unused_res;
        int          k;
        logic [15:0] interval_pick;
        logic [15:0] limit_pick;
        logic [15:0] addr_pick;

        ev_if.valid = 1'b0;
        ev_if.operation = bfrc_pkg::OP_SEND;
        ev_if.rx_sequence = '0;
        ev_if.rx_hops = '0;
        ev_if.rx_originator = '0;
        ev_if.random_value = '0;
        unused_res = '0;

        interval_reg = bfrc_pkg::BurstIntervalReset;
        limit_reg = bfrc_pkg::BurstLimitReset;
        addr_reg = '0;
        cur_seq = '0;
        held_hops = '0;
        held_orig = '0;
        tx_count = '0;
        held_valid = 1'b0;
        timer_on = 1'b0;
        timer_left = '0;

        // reset settings: interval 128, limit 3, own address 0
        add_event(bfrc_pkg::OP_TICK, 16'h0000, 8'h00, 16'h0000, 16'h0000,
                  1, 0, bfrc_pkg::ACT_TRANSMIT, 16'h0000, 8'h00, 16'h0000, 8'd0);
        add_event(bfrc_pkg::OP_RECEIVE, 16'h0000, 8'h00, 16'h1234, 16'h0000,
                  1, 1, bfrc_pkg::ACT_DUPLICATE, 16'h0000, 8'h01, 16'h1234, 8'd0);
        add_event(bfrc_pkg::OP_CANCEL, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF,
                  1, 0, bfrc_pkg::ACT_TRANSMIT, 16'h0000, 8'h00, 16'h0000, 8'd0);
        add_event(bfrc_pkg::OP_SEND, 16'hFFFF, 8'hFF, 16'hFFFF, 16'h0000,
                  1, 1, bfrc_pkg::ACT_TRANSMIT, 16'h0001, 8'h00, 16'h0000, 8'd1);
        // hop count saturates on forwarding
        add_event(bfrc_pkg::OP_RECEIVE, 16'h0001, 8'hFF, 16'hFFFF, 16'h0000,
                  1, 1, bfrc_pkg::ACT_DUPLICATE, 16'h0001, 8'hFF, 16'hFFFF, 8'd1);
        add_event(bfrc_pkg::OP_RECEIVE, 16'h0000, 8'h10, 16'h2222, 16'h0000,
                  1, 0, bfrc_pkg::ACT_TRANSMIT, 16'h0000, 8'h00, 16'h0000, 8'd0);
        // difference of exactly -5 is still slightly old
        add_event(bfrc_pkg::OP_RECEIVE, 16'hFFFC, 8'h10, 16'h3333, 16'h0000,
                  1, 0, bfrc_pkg::ACT_TRANSMIT, 16'h0000, 8'h00, 16'h0000, 8'd0);
        add_event(bfrc_pkg::OP_RECEIVE, 16'hFFFB, 8'h00, 16'hABCD, 16'h1234,
                  1, 1, bfrc_pkg::ACT_DELIVER, 16'hFFFB, 8'h01, 16'hABCD, 8'd1);
        add_event(bfrc_pkg::OP_RECEIVE, 16'h7FFA, 8'hFE, 16'h0000, 16'h8001,
                  1, 1, bfrc_pkg::ACT_DELIVER, 16'h7FFA, 8'hFF, 16'h0000, 8'd1);
        add_event(bfrc_pkg::OP_RECEIVE, 16'hFFFA, 8'h80, 16'h5555, 16'h7FFF,
                  0, 0, bfrc_pkg::ACT_TRANSMIT, 16'h0000, 8'h00, 16'h0000, 8'd0);
        // sequence above 255 wraps to 1
        add_event(bfrc_pkg::OP_SEND, 16'h0000, 8'h00, 16'h0000, 16'hFFFF,
                  1, 1, bfrc_pkg::ACT_TRANSMIT, 16'h0001, 8'h00, 16'h0000, 8'd1);

        // zero interval forces a one tick delay
        add_reg(bfrc_pkg::REG_BURST_INTERVAL, 16'h0000);
        add_reg(bfrc_pkg::REG_BURST_LIMIT, 16'h0003);
        add_reg(bfrc_pkg::REG_OWN_ADDRESS, 16'hFFFF);
        add_event(bfrc_pkg::OP_SEND, 16'h0000, 8'h00, 16'h0000, 16'hFFFF,
                  1, 1, bfrc_pkg::ACT_TRANSMIT, 16'h0002, 8'h00, 16'hFFFF, 8'd1);
        add_event(bfrc_pkg::OP_TICK, 16'h0000, 8'h00, 16'h0000, 16'h5A5A,
                  1, 1, bfrc_pkg::ACT_RETRANSMIT, 16'h0002, 8'h00, 16'hFFFF, 8'd2);
        add_event(bfrc_pkg::OP_TICK, 16'h0000, 8'h00, 16'h0000, 16'hA5A5,
                  1, 1, bfrc_pkg::ACT_RETRANSMIT, 16'h0002, 8'h00, 16'hFFFF, 8'd3);
        add_event(bfrc_pkg::OP_TICK, 16'h0000, 8'h00, 16'h0000, 16'h0000,
                  1, 0, bfrc_pkg::ACT_TRANSMIT, 16'h0000, 8'h00, 16'h0000, 8'd0);
        add_event(bfrc_pkg::OP_RECEIVE, 16'h0002, 8'h07, 16'h0042, 16'h0000,
                  1, 1, bfrc_pkg::ACT_DUPLICATE, 16'h0002, 8'h08, 16'h0042, 8'd3);
        add_event(bfrc_pkg::OP_CANCEL, 16'h0000, 8'h00, 16'h0000, 16'h0000,
                  1, 0, bfrc_pkg::ACT_TRANSMIT, 16'h0000, 8'h00, 16'h0000, 8'd0);
        add_event(bfrc_pkg::OP_TICK, 16'h0000, 8'h00, 16'h0000, 16'h0000,
                  1, 0, bfrc_pkg::ACT_TRANSMIT, 16'h0000, 8'h00, 16'h0000, 8'd0);

        // limit 1 leaves the timer stopped on delivery
        add_reg(bfrc_pkg::REG_BURST_INTERVAL, 16'hFFFF);
        add_reg(bfrc_pkg::REG_BURST_LIMIT, 16'h0001);
        add_reg(bfrc_pkg::REG_OWN_ADDRESS, 16'h0000);
        add_event(bfrc_pkg::OP_RECEIVE, 16'h0100, 8'h03, 16'h0BAD, 16'hFFFF,
                  1, 1, bfrc_pkg::ACT_DELIVER, 16'h0100, 8'h04, 16'h0BAD, 8'd1);
        add_event(bfrc_pkg::OP_TICK, 16'h0000, 8'h00, 16'h0000, 16'h0000,
                  1, 0, bfrc_pkg::ACT_TRANSMIT, 16'h0000, 8'h00, 16'h0000, 8'd0);
        add_event(bfrc_pkg::OP_SEND, 16'h0000, 8'h00, 16'h0000, 16'hFFFF,
                  1, 1, bfrc_pkg::ACT_TRANSMIT, 16'h0001, 8'h00, 16'h0000, 8'd1);
        add_event(bfrc_pkg::OP_CANCEL, 16'h0000, 8'h00, 16'h0000, 16'h0000,
                  1, 0, bfrc_pkg::ACT_TRANSMIT, 16'h0000, 8'h00, 16'h0000, 8'd0);

        // limit 0 still arms on a local send
        add_reg(bfrc_pkg::REG_BURST_INTERVAL, 16'h0002);
        add_reg(bfrc_pkg::REG_BURST_LIMIT, 16'h0000);
        add_reg(bfrc_pkg::REG_OWN_ADDRESS, 16'h8000);
        add_event(bfrc_pkg::OP_SEND, 16'h0000, 8'h00, 16'h0000, 16'h0000,
                  0, 0, bfrc_pkg::ACT_TRANSMIT, 16'h0000, 8'h00, 16'h0000, 8'd0);
        add_event(bfrc_pkg::OP_TICK, 16'h0000, 8'h00, 16'h0000, 16'h0000,
                  1, 1, bfrc_pkg::ACT_RETRANSMIT, 16'h0002, 8'h00, 16'h8000, 8'd2);
        add_event(bfrc_pkg::OP_TICK, 16'h0000, 8'h00, 16'h0000, 16'h0000,
                  1, 0, bfrc_pkg::ACT_TRANSMIT, 16'h0000, 8'h00, 16'h0000, 8'd0);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (stim_table[i])
        begin
            if (stim_table[i].is_reg)
            begin
                wait_idle();
                write_reg(stim_table[i].idx, stim_table[i].data);
            end
            else
                issue_event(stim_table[i].ev, pick_gap(), stim_table[i].typed,
                            stim_table[i].has_exp, stim_table[i].exp);
        end

        for (int p = 0; p < Phases; p++)
        begin
            wait_idle();
            k = $urandom_range(0, 7);
            if (k == 0)
                interval_pick = 16'd0;
            else if (k == 1)
                interval_pick = 16'd1;
            else if (k < 6)
                interval_pick = 16'($urandom_range(2, 24));
            else if (k == 6)
                interval_pick = 16'($urandom_range(25, 300));
            else
                interval_pick = 16'($urandom_range(0, 65535));
            k = $urandom_range(0, 7);
            if (k == 0)
                limit_pick = 16'd0;
            else if (k == 1)
                limit_pick = 16'd1;
            else if (k < 6)
                limit_pick = 16'($urandom_range(2, 6));
            else if (k == 6)
                limit_pick = 16'd255;
            else
                limit_pick = 16'($urandom_range(0, 65535));
            addr_pick = 16'($urandom_range(0, 65535));
            if (p == 1)
            begin
                interval_pick = 16'd2;
                limit_pick = 16'd255;
            end
            else if (p == 2)
            begin
                interval_pick = 16'hFFFF;
                limit_pick = 16'd0;
            end
            write_reg(bfrc_pkg::REG_BURST_INTERVAL, interval_pick);
            write_reg(bfrc_pkg::REG_BURST_LIMIT, limit_pick);
            write_reg(bfrc_pkg::REG_OWN_ADDRESS, addr_pick);
            no_idle = (p == Phases - 1);

            // back-to-back sends while results are held off fill the block
            if (p == 0)
            begin
                hold_request = 1'b1;
                pressing = 1'b1;
                repeat (12)
                begin
                    ev = pick_event(1'b1);
                    issue_event(ev, 0, 1'b0, 1'b0, unused_res);
                end
                pressing = 1'b0;
            end

            repeat (PhaseItems)
            begin
                ev = pick_event(1'b0);
                issue_event(ev, pick_gap(), 1'b0, 1'b0, unused_res);
            end
        end

        @(negedge clk);
        ev_if.valid <= 1'b0;
        k = 0;
        while (flood_results.size() != 0 && k < DrainLimit)
        begin
            @(posedge clk);
            k++;
        end
        repeat (IdleWait) @(posedge clk);
        if (flood_results.size() != 0)
            flag_error($sformatf("%0d results never arrived", flood_results.size()));

        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
